/* design/i2rt_pkg.sv */
// Shared constants, types and helper functions for the integer to radix text converter.
package i2rt_pkg;

  // Default operand width and configuration register layout.
  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_W        = 6;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  // Register index of the radix register.
  localparam logic REG_RADIX = 1'b0;

  // Legal radix range and reset value.
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
  localparam logic [RADIX_W-1:0] DECIMAL_RADIX = 6'd10;

  // Character codes.
  localparam logic [7:0] CHAR_ZERO        = 8'h30;
  localparam logic [7:0] CHAR_LETTER_BASE = 8'h37;
  localparam logic [7:0] CHAR_MINUS       = 8'h2D;

  // Quotient bits resolved per cycle by the divider.
  localparam int DIV_STEP = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } i2rt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic quot_zero;
    logic emit_last;
    logic out_free;
  } i2rt_sts_t;

  // Map a digit value to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [7:0] dw;
    dw = {2'b00, d};
    if (d < RADIX_W'(10)) begin
      return dw + CHAR_ZERO;
    end
    return dw + CHAR_LETTER_BASE;
  endfunction

  // Clamp a written radix into the legal range.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

endpackage

/* design/i2rt_ctrl.sv */
// Controller state machine: sequences load, digit division and character output.
module i2rt_ctrl
  import i2rt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  i2rt_sts_t sts,
  output i2rt_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done && sts.quot_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        if (sts.out_free && sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/i2rt_dp.sv */
// Datapath: magnitude load, radix divider, digit stack and output register.
module i2rt_dp
  import i2rt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [RADIX_W-1:0]    radix,
  input  i2rt_cmd_t             cmd,
  output i2rt_sts_t             sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            out_text_char,
  output logic                  out_last_char
);

  localparam int DIV_W  = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int NSTEP  = DIV_W / DIV_STEP;
  localparam int CNT_W  = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int NDIG_W = $clog2(VALUE_BITS + 1);

  logic [DIV_W-1:0]   acc_r;
  logic [DIV_W-1:0]   acc_nxt;
  logic [RADIX_W-1:0] rem_r;
  logic [RADIX_W-1:0] rem_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [NDIG_W-1:0]  ndig_r;
  logic               neg_r;
  logic               neg_in;
  logic [VALUE_BITS-1:0] mag;
  logic [RADIX_W-1:0] stk_r [VALUE_BITS];
  logic               out_valid_r;
  logic [7:0]         out_char_r;
  logic               out_last_r;
  logic               div_last;

  // Sign handling: only radix ten shows a minus sign.
  always_comb begin
    neg_in = (radix == DECIMAL_RADIX) && in_value[VALUE_BITS-1];
    mag    = neg_in ? (VALUE_BITS'(0) - in_value) : in_value;
  end

  // Restoring division, DIV_STEP quotient bits per cycle.
  always_comb begin
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    logic [DIV_W-1:0]   a;
    r = rem_r;
    a = acc_r;
    for (int k = 0; k < DIV_STEP; k++) begin
      t = {r, a[DIV_W-1]};
      a = {a[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, radix}) begin
        t    = t - {1'b0, radix};
        a[0] = 1'b1;
      end
      r = t[RADIX_W-1:0];
    end
    acc_nxt = a;
    rem_nxt = r;
  end

  assign div_last = (cnt_r == CNT_W'(NSTEP - 1));

  // Status toward the controller.
  always_comb begin
    sts.div_done  = div_last;
    sts.quot_zero = (acc_nxt == '0);
    sts.emit_last = !neg_r && (ndig_r == NDIG_W'(1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Control registers: step counter, digit count, sign flag, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ndig_r      <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r  <= '0;
        ndig_r <= '0;
        neg_r  <= neg_in;
      end
      if (cmd.div_step) begin
        cnt_r <= div_last ? '0 : cnt_r + CNT_W'(1);
        if (div_last) begin
          ndig_r <= ndig_r + NDIG_W'(1);
        end
      end
      if (cmd.emit) begin
        if (neg_r) begin
          neg_r <= 1'b0;
        end else begin
          ndig_r <= ndig_r - NDIG_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: dividend/quotient, remainder, digit stack, output beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= DIV_W'(mag);
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      acc_r <= acc_nxt;
      rem_r <= div_last ? '0 : rem_nxt;
      if (div_last) begin
        stk_r[0] <= rem_nxt;
        for (int i = 1; i < VALUE_BITS; i++) begin
          stk_r[i] <= stk_r[i-1];
        end
      end
    end
    if (cmd.emit) begin
      if (neg_r) begin
        out_char_r <= CHAR_MINUS;
        out_last_r <= 1'b0;
      end else begin
        out_char_r <= digit_char(stk_r[0]);
        out_last_r <= (ndig_r == NDIG_W'(1));
        for (int i = 0; i < VALUE_BITS - 1; i++) begin
          stk_r[i] <= stk_r[i+1];
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

endmodule

/* design/integer_to_radix_text.sv */
// Top level of the integer to radix text converter: register port, controller and datapath.
//
// Usage: write the radix (2 to 36, reset value 10) over the APB-style port at
// byte addresses 0 to 3; writes outside the range are clamped, writes to
// addresses with paddr[2] set are ignored. Each input beat on in_value (a two's
// complement integer) produces one output beat per character, most significant digit
// first, with out_last_char set on the final beat. A minus sign leads the
// text only in radix ten; other radixes print the unsigned bit pattern.
// Timing: the value is loaded, then each digit comes from the shared
// divider at four quotient bits per cycle, then characters leave at one
// per cycle while the receiver takes them.
// in_ready is high only while no item is in progress; the final character
// may still wait in the output register while the next item is taken.
// A stalled receiver holds the current beat and pauses character output.
// Reset (synchronous, rst_n low) drops any item in progress, clears the
// output valid flag and restores radix ten.
module integer_to_radix_text
  import i2rt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_text_char,
  output logic                         out_last_char,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready
);

  logic [RADIX_W-1:0] cfg_radix_r;
  logic               cfg_wr;
  i2rt_cmd_t          cmd;
  i2rt_sts_t          sts;

  // Register port: single radix register, clamped on write.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_radix_r <= RADIX_RESET;
    end else if (cfg_wr) begin
      cfg_radix_r <= clamp_radix(pwdata[RADIX_W-1:0]);
    end
  end

  assign prdata = (paddr[2] == REG_RADIX) ? APB_DATA_W'(cfg_radix_r) : '0;

  // Controller.
  i2rt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  i2rt_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      ($unsigned(in_value)),
    .radix         (cfg_radix_r),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  // An accepted beat starts work, so the input closes on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after an accepted beat");

  // The radix register never leaves its legal range.
  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_radix_r >= RADIX_MIN && cfg_radix_r <= RADIX_MAX)
    else $error("radix register out of range");

  // A minus sign is always followed by digits.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_text_char == CHAR_MINUS) |-> !out_last_char)
    else $error("minus sign marked as final character");

endmodule

/* tb/radix_text_checker.sv */
`timescale 1ns / 1ps
// Checker for the integer to radix text converter: predicts every character beat and compares.
module radix_text_checker
  import i2rt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_text_char,
  input  logic                  out_last_char,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    failures,
  output int                    pending,
  output int                    chars_checked
);

  // Only the first few mismatches are printed; all of them are counted.
  localparam int SHOWN_LIMIT = 30;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  // Characters still owed by the converter, oldest first.
  text_beat_t chars_due[$];
  // Radix as the converter should hold it after the writes seen so far.
  logic [RADIX_W-1:0] radix_now;

  initial begin
    failures      = 0;
    pending       = 0;
    chars_checked = 0;
    radix_now     = RADIX_RESET;
  end

  task automatic report_mismatch(input string what);
    if (failures < SHOWN_LIMIT) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    failures++;
  endtask

  // Expected characters of one number in the current radix, most significant first.
  function automatic void predict_text(input logic [VALUE_BITS-1:0] num);
    logic [VALUE_BITS-1:0] mag;
    logic [RADIX_W-1:0]    d;
    logic [7:0]            digit_chars[$];
    logic                  minus;
    text_beat_t            beat;
    minus = (radix_now == DECIMAL_RADIX) && num[VALUE_BITS-1];
    mag = minus ? -num : num;
    // Digits come out least significant first; zero still yields one digit.
    do begin
      d = RADIX_W'(mag % radix_now);
      digit_chars.push_back(d < DECIMAL_RADIX ? CHAR_ZERO + 8'(d) : CHAR_LETTER_BASE + 8'(d));
      mag = mag / radix_now;
    end while (mag != 0);
    if (minus) begin
      beat.ch   = CHAR_MINUS;
      beat.last = 1'b0;
      chars_due.push_back(beat);
    end
    for (int i = digit_chars.size() - 1; i >= 0; i--) begin
      beat.ch   = digit_chars[i];
      beat.last = (i == 0);
      chars_due.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : watch
    text_beat_t         want;
    logic [RADIX_W-1:0] raw;
    if (!rst_n) begin
      radix_now = RADIX_RESET;
      chars_due.delete();
    end else begin
      // Result side first: a beat leaving now belongs to a number taken earlier.
      if (out_valid && out_ready) begin
        chars_checked++;
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing expected", out_text_char));
        end else begin
          want = chars_due.pop_front();
          if (out_text_char !== want.ch) begin
            report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h (radix %0d)",
                                      out_text_char, want.ch, radix_now));
          end
          if (out_last_char !== want.last) begin
            report_mismatch($sformatf("last_char %b, expected %b on character 0x%02h",
                                      out_last_char, want.last, want.ch));
          end
        end
      end

      if (in_valid && in_ready) begin
        predict_text(in_value);
      end

      // Register port: writes to the radix are clamped, reads return the held value.
      if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_RADIX &&
          paddr[1:0] == 2'b00) begin
        if (pwrite) begin
          raw = pwdata[RADIX_W-1:0];
          if (raw < RADIX_MIN) begin
            radix_now = RADIX_MIN;
          end else if (raw > RADIX_MAX) begin
            radix_now = RADIX_MAX;
          end else begin
            radix_now = raw;
          end
        end else if (prdata !== APB_DATA_W'(radix_now)) begin
          report_mismatch($sformatf("radix read 0x%08h, expected %0d", prdata, radix_now));
        end
      end
    end
    pending <= chars_due.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the integer to radix text converter: clock, reset, stimulus and verdict.
module tb;
  import i2rt_pkg::*;

  localparam int VALUE_W       = VALUE_BITS_DEF;
  localparam int QUIET_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 40;
  localparam int TAIL_CYCLES   = 300;
  localparam logic [APB_ADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_RADIX, 2'b00};

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [VALUE_W-1:0]   in_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [7:0]                  out_text_char;
  logic                        out_last_char;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [APB_ADDR_W-1:0]       paddr;
  logic [APB_DATA_W-1:0]       pwdata;
  logic [APB_DATA_W-1:0]       prdata;
  logic                        pready;

  // When calm is set neither side inserts idle cycles.
  logic                        calm;
  logic [RADIX_W-1:0]          cur_radix;
  int                          numbers_sent;
  int                          settings_used;
  int                          quiet_cycles;
  int                          failures;
  int                          pending;
  int                          chars_checked;

  always #5 clk = ~clk;

  integer_to_radix_text #(.VALUE_BITS(VALUE_W)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_text_char(out_text_char), .out_last_char(out_last_char),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  radix_text_checker #(.VALUE_BITS(VALUE_W)) text_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_text_char(out_text_char), .out_last_char(out_last_char),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .failures(failures), .pending(pending), .chars_checked(chars_checked)
  );

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d characters outstanding",
                 QUIET_LIMIT, pending);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver: before each character beat, stall for a random number of cycles.
  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Offer one number after a random gap and hold it until the converter takes the beat.
  task automatic send_number(input logic [VALUE_W-1:0] num);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= num;
    do @(posedge clk); while (!in_ready);
    numbers_sent++;
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic reg_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the radix, read it back, and note the value the converter should now use.
  task automatic set_radix(input logic [APB_DATA_W-1:0] data);
    logic [RADIX_W-1:0] raw;
    raw = data[RADIX_W-1:0];
    reg_access(1'b1, RADIX_ADDR, data);
    reg_access(1'b0, RADIX_ADDR, '0);
    cur_radix = (raw < RADIX_MIN) ? RADIX_MIN : ((raw > RADIX_MAX) ? RADIX_MAX : raw);
    settings_used++;
  endtask

  // Stop offering numbers and wait until every owed character has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Random number shaped for text conversion: full range, short texts, negatives,
  // values next to a power of the radix, and the extremes.
  function automatic logic [VALUE_W-1:0] pick_number();
    logic [63:0]        pw;
    int                 steps;
    logic [VALUE_W-1:0] num;
    case ($urandom_range(0, 5))
      0: num = $urandom();
      1: num = $urandom_range(0, 40);
      2: num = -$urandom_range(1, 40);
      3: begin
        pw = 64'd1;
        steps = $urandom_range(1, 32);
        repeat (steps) begin
          if (pw * cur_radix < (64'd1 << VALUE_W)) begin
            pw = pw * cur_radix;
          end
        end
        num = VALUE_W'(pw + $urandom_range(0, 2) - 1);
      end
      4: num = $urandom() >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 3))
          0: num = '1;
          1: num = {1'b1, {(VALUE_W-1){1'b0}}};
          2: num = {1'b0, {(VALUE_W-1){1'b1}}};
          default: num = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
        endcase
      end
    endcase
    return num;
  endfunction

  initial begin
    logic [APB_DATA_W-1:0] wdata;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    calm          = 1'b0;
    cur_radix     = RADIX_RESET;
    numbers_sent  = 0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Decimal after reset: zero, sign handling, the most negative value and the extremes.
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'd9);
    send_number(32'd10);
    send_number(-32'sd10);
    send_number(32'd1_000_000_000);

    // A write of zero clamps to binary: longest texts, negatives as raw bit patterns.
    wait_drained();
    set_radix(32'd0);
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'd1);
    send_number(32'h5555_5555);

    // The largest six-bit write clamps to base 36, which reaches the letter Z.
    wait_drained();
    set_radix(32'd63);
    send_number(32'd35);
    send_number(32'd36);
    send_number(32'hFFFF_FFFF);

    // Bits above the six-bit field are dropped, leaving hexadecimal.
    wait_drained();
    set_radix(32'h0000_0050);
    send_number(32'hFEDC_BA98);
    send_number(32'h0123_4567);

    // A write to the unused address must leave the radix alone.
    wait_drained();
    reg_access(1'b1, SPARE_ADDR, 32'd3);
    reg_access(1'b0, RADIX_ADDR, '0);
    send_number(32'd255);

    // Clamping from just below the minimum and just above the maximum.
    wait_drained();
    set_radix(32'd1);
    set_radix(32'd37);
    send_number(32'h8000_0000);

    // Random phases: the first few pin the edge radixes, later ones draw raw writes.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: wdata = APB_DATA_W'(RADIX_MIN);
        1: wdata = APB_DATA_W'(RADIX_MAX);
        2: wdata = APB_DATA_W'(DECIMAL_RADIX);
        3: wdata = 32'd3;
        4: wdata = 32'd35;
        default: begin
          case ($urandom_range(0, 3))
            0: wdata = $urandom();
            1: wdata = $urandom_range(0, 63);
            default: wdata = $urandom_range(2, 36);
          endcase
        end
      endcase
      set_radix(wdata);
      calm = (ph % 4 == 3);
      repeat (PHASE_ITEMS) send_number(pick_number());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d numbers under %0d radix settings; %0d characters compared.",
             numbers_sent, settings_used, chars_checked);
    $display("Radix writes covered clamping at both ends, dropped high bits and an unused address.");
    if (failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
